// ===== hw/rtl/sjis_pkg.sv =====
// ----------------------------------------------------------------------------
// sjis_pkg
// Shared types, codes and the UTF-8 byte packer for the Shift-JIS transcoder.
// ----------------------------------------------------------------------------
package sjis_pkg;

    localparam int CODE_WIDTH      = 16;
    localparam int LEAD_DEPTH      = 256;
    localparam int PAIR_DEPTH      = 65536;
    localparam int MAX_BYTES       = 3;

    // item opcodes
    localparam logic [1:0] OP_STREAM    = 2'd0;
    localparam logic [1:0] OP_WR_LEAD   = 2'd1;
    localparam logic [1:0] OP_WR_PAIR   = 2'd2;

    // special bytes
    localparam logic [7:0] BYTE_ESC2    = 8'h10;   // passes with next two
    localparam logic [7:0] BYTE_ESC1    = 8'h80;   // passes with next one
    localparam logic [7:0] BYTE_CTL_MAX = 8'h1C;
    localparam logic [7:0] UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0] UTF8_CONT    = 8'h80;

    typedef logic [CODE_WIDTH-1:0] code_t;
    typedef logic [MAX_BYTES-1:0][7:0] byte_buf_t;   // index 0 goes out first

    typedef struct packed {
        byte_buf_t  bytes;
        logic [1:0] count;
    } utf8_seq_t;

    function automatic utf8_seq_t utf8_encode(input code_t code);
        utf8_seq_t s;
        s.bytes = '0;
        if (code < 16'h0080) begin
            s.count    = 2'd1;
            s.bytes[0] = code[7:0];
        end
        else if (code < 16'h0800) begin
            s.count    = 2'd2;
            s.bytes[0] = UTF8_LEAD2 | {3'b000, code[10:6]};
            s.bytes[1] = UTF8_CONT  | {2'b00, code[5:0]};
        end
        else begin
            s.count    = 2'd3;
            s.bytes[0] = UTF8_LEAD3 | {4'b0000, code[15:12]};
            s.bytes[1] = UTF8_CONT  | {2'b00, code[11:6]};
            s.bytes[2] = UTF8_CONT  | {2'b00, code[5:0]};
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/sjis_ram.sv =====
// ----------------------------------------------------------------------------
// sjis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sjis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sjis_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// sjis_to_utf8_transcoder
// Shift-JIS byte stream in, UTF-8 bytes out, with RAM-held lead/pair tables.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | op, stream_byte, table_address, table_value
//  out     | out_valid/out_ready| out_byte, last_of_run
//
//  Table reads launch when an item is accepted, and the item is decided in
//  the following cycle from the registered RAM data.
//  The output buffer drains one byte per cycle while out_ready is high; a
//  stream item yields up to 3 UTF-8 bytes, and that buffer sets the sustained rate.
//  Table writes and lead bytes emit nothing.
//  Reset clears pass-through and lead state and empties both stages; the
//  tables are not cleared and hold garbage until written.
//  A stalled output holds the decode stage, which in turn drops in_ready.
//
module sjis_to_utf8_transcoder
    import sjis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  stream_byte,
    input  logic [15:0] table_address,
    input  logic [15:0] table_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);

    // ------------------------------------------------------------------
    // accept stage: table writes go straight to RAM, stream bytes launch
    // both lookups. The pair read is speculative: it pairs this byte with
    // the previous stream byte, which is the held lead if one is waiting.
    // ------------------------------------------------------------------
    logic       in_acc;
    logic       acc_stream;
    logic [7:0] prev_byte_reg;
    code_t      lead_rdata;
    code_t      pair_rdata;

    assign in_acc     = in_valid && in_ready;
    assign acc_stream = in_acc && (op == OP_STREAM);

    sjis_ram #(
        .WIDTH (CODE_WIDTH),
        .DEPTH (LEAD_DEPTH)
    ) u_lead_ram (
        .clk     (clk),
        .wr_en   (in_acc && (op == OP_WR_LEAD)),
        .wr_addr (table_address[7:0]),
        .wr_data (table_value),
        .rd_en   (acc_stream),
        .rd_addr (stream_byte),
        .rd_data (lead_rdata)
    );

    sjis_ram #(
        .WIDTH (CODE_WIDTH),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_ram (
        .clk     (clk),
        .wr_en   (in_acc && (op == OP_WR_PAIR)),
        .wr_addr (table_address),
        .wr_data (table_value),
        .rd_en   (acc_stream),
        .rd_addr ({prev_byte_reg, stream_byte}),
        .rd_data (pair_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (acc_stream)
        begin
            prev_byte_reg <= stream_byte;
        end
    end

    // ------------------------------------------------------------------
    // decode stage: runs the byte against pass-through / lead state and
    // the RAM data, and hands the resulting bytes to the output buffer.
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic [1:0] pt_left_reg, pt_left_next;
    logic       lead_wait_reg, lead_wait_next;
    utf8_seq_t  s1_seq;
    logic       s1_adv;

    byte_buf_t  obuf_reg, obuf_next;
    logic [1:0] ocnt_reg, ocnt_next;
    logic       obuf_free;

    always_comb
    begin
        pt_left_next   = pt_left_reg;
        lead_wait_next = lead_wait_reg;
        s1_seq.bytes   = '0;
        s1_seq.count   = 2'd0;
        if (pt_left_reg != 2'd0)
        begin
            // raw byte inside an escape run
            pt_left_next    = pt_left_reg - 2'd1;
            s1_seq.bytes[0] = s1_byte_reg;
            s1_seq.count    = 2'd1;
        end
        else if (lead_wait_reg)
        begin
            // trail byte: any value, looked up in the pair table
            lead_wait_next = 1'b0;
            s1_seq         = utf8_encode(pair_rdata);
        end
        else if ((s1_byte_reg <= BYTE_CTL_MAX) || (s1_byte_reg == BYTE_ESC1))
        begin
            if (s1_byte_reg == BYTE_ESC2)
            begin
                pt_left_next = 2'd2;
            end
            else if (s1_byte_reg == BYTE_ESC1)
            begin
                pt_left_next = 2'd1;
            end
            s1_seq.bytes[0] = s1_byte_reg;
            s1_seq.count    = 2'd1;
        end
        else if (lead_rdata != '0)
        begin
            s1_seq = utf8_encode(lead_rdata);
        end
        else
        begin
            // lead byte: wait for its trail, nothing out yet
            lead_wait_next = 1'b1;
        end
    end

    assign obuf_free = (ocnt_reg == 2'd0) || ((ocnt_reg == 2'd1) && out_ready);
    assign s1_adv    = s1_valid_reg && ((s1_seq.count == 2'd0) || obuf_free);
    assign in_ready  = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pt_left_reg   <= 2'd0;
            lead_wait_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= (op == OP_STREAM);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                pt_left_reg   <= pt_left_next;
                lead_wait_reg <= lead_wait_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_stream)
        begin
            s1_byte_reg <= stream_byte;
        end
    end

    // ------------------------------------------------------------------
    // output buffer: up to three bytes, shifted out while out_ready is high, one per cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        obuf_next = obuf_reg;
        ocnt_next = ocnt_reg;
        if (out_valid && out_ready)
        begin
            obuf_next = {8'h00, obuf_reg[2], obuf_reg[1]};
            ocnt_next = ocnt_reg - 2'd1;
        end
        if (s1_adv && (s1_seq.count != 2'd0))
        begin
            obuf_next = s1_seq.bytes;
            ocnt_next = s1_seq.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= 2'd0;
        end
        else
        begin
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obuf_reg <= obuf_next;
    end

    assign out_valid   = (ocnt_reg != 2'd0);
    assign out_byte    = obuf_reg[0];
    assign last_of_run = (ocnt_reg == 2'd1);

`ifndef NO_ASSERTIONS
    // escape run and lead wait never overlap
    a_state_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(lead_wait_reg && (pt_left_reg != 2'd0)))
        else $error("pass-through and lead wait both active");

    // a held decode item keeps its byte
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("decode stage lost a stalled item");

    // input only blocks behind a pending decode item
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && (ocnt_reg != 2'd0)))
        else $error("in_ready low without a pending item");

    // new bytes are only loaded into a draining or empty buffer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_seq.count != 2'd0)) |-> obuf_free)
        else $error("output buffer overwritten");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Shift-JIS to UTF-8 transcoder: a directed
// table of items, then random byte streams, with every output byte checked against
// typed-in expectations or a local predictor under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sjis_pkg::*;

    // op code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // stop stimulus once this many non-ignored items went in
    localparam int RANDOM_ITEMS = 450;
    // sender pauses for a full drain every this many items
    localparam int DRAIN_EVERY  = 150;
    // receiver holds off this long once per HOLD_EVERY output bytes
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_EVERY   = 300;
    // settle time after the last byte, and the overall run limit
    localparam int TAIL_CYCLES  = 20;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // one input item, plus an optional typed-in expectation
    // (typed_n bytes, first out in the highest used byte of typed_bytes)
    typedef struct {
        logic [1:0]  op;
        logic [7:0]  stream_byte;
        logic [15:0] table_address;
        logic [15:0] table_value;
        int          typed_n;
        logic [23:0] typed_bytes;
    } sjis_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } utf8_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_STREAM;
    logic [7:0]  stream_byte = 8'h00;
    logic [15:0] table_address = 16'h0000;
    logic [15:0] table_value = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;

    // predictor state: both tables, which entries hold a value, and the
    // pending raw pass-through / lead-byte state
    logic [15:0] lead_map [256];
    logic [15:0] pair_map [65536];
    bit          lead_known [256];
    bit          pair_known [65536];
    logic [1:0]  raw_left = 2'd0;
    logic        lead_pending = 1'b0;
    logic [7:0]  held_lead = 8'h00;

    utf8_byte_t  predicted [$];      // bytes the current item produces
    utf8_byte_t  utf8_expected [$];  // bytes still owed by the block
    utf8_byte_t  want;

    int          mismatches = 0;
    int          item_count = 0;
    int          burst_left = 0;
    int          rx_cycle = 0;
    int          rx_taken = 0;
    int          hold_left = 0;
    int          next_hold = HOLD_EVERY / 2;

    sjis_to_utf8_transcoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .stream_byte   (stream_byte),
        .table_address (table_address),
        .table_value   (table_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic sjis_item_t make_item(input logic [1:0] op_code,
                                             input logic [7:0] sb,
                                             input logic [15:0] addr,
                                             input logic [15:0] val,
                                             input int n,
                                             input logic [23:0] bytes);
        sjis_item_t it;
        it.op            = op_code;
        it.stream_byte   = sb;
        it.table_address = addr;
        it.table_value   = val;
        it.typed_n       = n;
        it.typed_bytes   = bytes;
        return it;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic last);
        utf8_byte_t r;
        r.data = b;
        r.last = last;
        predicted.push_back(r);
    endfunction

    // UTF-8 for a 16-bit code point: 1, 2 or 3 bytes
    function automatic void emit_code(input logic [15:0] cp);
        if (cp < 16'h0080)
        begin
            emit(cp[7:0], 1'b1);
        end
        else if (cp < 16'h0800)
        begin
            emit(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b0);
            emit(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1);
        end
        else
        begin
            emit(UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b0);
            emit(UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
            emit(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1);
        end
    endfunction

    // Advances the predicted state by one item; fills 'predicted'.
    function automatic void transcode_item(input sjis_item_t it);
        predicted.delete();
        case (it.op)
            OP_WR_LEAD:
            begin
                // only the low address byte selects the entry
                lead_map[it.table_address[7:0]]   = it.table_value;
                lead_known[it.table_address[7:0]] = 1'b1;
            end
            OP_WR_PAIR:
            begin
                pair_map[it.table_address]   = it.table_value;
                pair_known[it.table_address] = 1'b1;
            end
            OP_STREAM:
            begin
                if (raw_left != 2'd0)
                begin
                    // raw pass-through: no lookup, no escape detection
                    raw_left = raw_left - 2'd1;
                    emit(it.stream_byte, 1'b1);
                end
                else if (lead_pending)
                begin
                    // any byte is a trail, control bytes included
                    lead_pending = 1'b0;
                    emit_code(pair_map[{held_lead, it.stream_byte}]);
                end
                else if (it.stream_byte <= BYTE_CTL_MAX || it.stream_byte == BYTE_ESC1)
                begin
                    if (it.stream_byte == BYTE_ESC2)
                        raw_left = 2'd2;
                    else if (it.stream_byte == BYTE_ESC1)
                        raw_left = 2'd1;
                    emit(it.stream_byte, 1'b1);
                end
                else if (lead_map[it.stream_byte] != 16'h0000)
                begin
                    emit_code(lead_map[it.stream_byte]);
                end
                else
                begin
                    // lead byte: wait for the trail, nothing out yet
                    lead_pending = 1'b1;
                    held_lead    = it.stream_byte;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one item, waits for the handshake, then books its output bytes.
    // Called at a rising edge; returns at the edge where the next item may go.
    task automatic send_item(input sjis_item_t it);
        utf8_byte_t r;
        op            <= it.op;
        stream_byte   <= it.stream_byte;
        table_address <= it.table_address;
        table_value   <= it.table_value;
        in_valid      <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);

        transcode_item(it);
        if (it.typed_n != 0)
        begin
            for (int k = 0; k < it.typed_n; k++)
            begin
                r.data = it.typed_bytes[8 * (it.typed_n - 1 - k) +: 8];
                r.last = (k == it.typed_n - 1);
                utf8_expected.push_back(r);
            end
        end
        else
        begin
            foreach (predicted[k])
                utf8_expected.push_back(predicted[k]);
        end
        if (it.op != OP_UNUSED)
            item_count++;

        // bursts of random length, some long, with short random gaps between
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Sender goes quiet until every booked byte has come out.
    task automatic drain_results();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (utf8_expected.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_code(input bit allow_zero);
        case ($urandom_range(0, 9))
            0:
                return allow_zero ? 16'h0000 : 16'h007F;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h0001;
                    1: return 16'h0080;
                    2: return 16'h07FF;
                    3: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
            2, 3:
                return 16'($urandom_range(16'h0001, 16'h007F));
            4, 5, 6:
                return 16'($urandom_range(16'h0080, 16'h07FF));
            default:
                return 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
    endfunction

    // One stream byte that is legal for the current state. Table entries the
    // byte will read are written first, so no unwritten entry is ever used.
    task automatic stream_step();
        logic [7:0] b;
        if (raw_left != 2'd0)
        begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                b = $urandom_range(0, 1) ? BYTE_ESC2 : BYTE_ESC1;
        end
        else if (lead_pending)
        begin
            b = 8'($urandom_range(0, 255));
            // pair writes land between lead and trail on purpose
            if (!pair_known[{held_lead, b}] || $urandom_range(0, 9) == 0)
                send_item(make_item(OP_WR_PAIR, 8'($urandom), {held_lead, b},
                                    rand_code(1'b1), 0, 24'h0));
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0: b = BYTE_ESC2;
                1: b = BYTE_ESC1;
                default: b = 8'($urandom_range(0, BYTE_CTL_MAX));
            endcase
        end
        else
        begin
            do
            begin
                b = 8'($urandom_range(BYTE_CTL_MAX + 1, 255));
            end
            while (b == BYTE_ESC1);
            if (!lead_known[b])
                send_item(make_item(OP_WR_LEAD, 8'($urandom), {8'($urandom), b},
                                    ($urandom_range(0, 9) < 4) ? 16'h0000
                                                               : rand_code(1'b0),
                                    0, 24'h0));
        end
        send_item(make_item(OP_STREAM, b, 16'($urandom), 16'($urandom), 0, 24'h0));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial
    begin
        sjis_item_t script [$];
        int         pick;
        int         next_drain;

        next_drain = DRAIN_EVERY;

        // directed: all escapes, control extremes, lead/trail, each UTF-8 length at
        // its top edge, writes and an ignored op while a lead waits
        script.push_back(make_item(OP_WR_LEAD, 8'h00, 16'h0041, 16'h007F, 0, 24'h0));
        script.push_back(make_item(OP_STREAM,  8'h41, 16'h0000, 16'h0000, 1, 24'h00007F));
        script.push_back(make_item(OP_STREAM,  8'h00, 16'h0000, 16'h0000, 1, 24'h000000));
        script.push_back(make_item(OP_STREAM,  8'h1C, 16'h0000, 16'h0000, 1, 24'h00001C));
        // two-byte escape: 0x10 then two raw bytes, even 0x80
        script.push_back(make_item(OP_STREAM,  8'h10, 16'h0000, 16'h0000, 1, 24'h000010));
        script.push_back(make_item(OP_STREAM,  8'hFF, 16'h0000, 16'h0000, 1, 24'h0000FF));
        script.push_back(make_item(OP_STREAM,  8'h80, 16'h0000, 16'h0000, 1, 24'h000080));
        // one-byte escape, whose raw byte is 0x10 and must not re-arm
        script.push_back(make_item(OP_STREAM,  8'h80, 16'h0000, 16'h0000, 1, 24'h000080));
        script.push_back(make_item(OP_STREAM,  8'h10, 16'h0000, 16'h0000, 1, 24'h000010));
        // lead entry with the upper address byte set (ignored)
        script.push_back(make_item(OP_WR_LEAD, 8'h00, 16'hFF81, 16'h0000, 0, 24'h0));
        script.push_back(make_item(OP_WR_PAIR, 8'h00, 16'h8140, 16'h3000, 0, 24'h0));
        script.push_back(make_item(OP_STREAM,  8'h81, 16'h0000, 16'h0000, 0, 24'h0));
        script.push_back(make_item(OP_WR_PAIR, 8'h00, 16'h81FF, 16'hFFFF, 0, 24'h0));
        script.push_back(make_item(OP_UNUSED,  8'h40, 16'hFFFF, 16'hFFFF, 0, 24'h0));
        script.push_back(make_item(OP_STREAM,  8'h40, 16'h0000, 16'h0000, 3, 24'hE38080));
        script.push_back(make_item(OP_STREAM,  8'h81, 16'h0000, 16'h0000, 0, 24'h0));
        script.push_back(make_item(OP_STREAM,  8'hFF, 16'h0000, 16'h0000, 3, 24'hEFBFBF));
        // control byte as trail, pair entry holding code point zero
        script.push_back(make_item(OP_WR_PAIR, 8'h00, 16'h8100, 16'h0000, 0, 24'h0));
        script.push_back(make_item(OP_STREAM,  8'h81, 16'h0000, 16'h0000, 0, 24'h0));
        script.push_back(make_item(OP_STREAM,  8'h00, 16'h0000, 16'h0000, 1, 24'h000000));
        script.push_back(make_item(OP_WR_LEAD, 8'h00, 16'h00A1, 16'h07FF, 0, 24'h0));
        script.push_back(make_item(OP_STREAM,  8'hA1, 16'h0000, 16'h0000, 2, 24'h00DFBF));
        script.push_back(make_item(OP_WR_LEAD, 8'h00, 16'h00FE, 16'h0080, 0, 24'h0));
        script.push_back(make_item(OP_STREAM,  8'hFE, 16'h0000, 16'h0000, 2, 24'h00C280));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
            send_item(script[k]);
        drain_results();

        // random: mostly legal byte streams, some table rewrites and noise
        while (item_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_item(make_item(OP_UNUSED, 8'($urandom), 16'($urandom),
                                    16'($urandom), 0, 24'h0));
            else if (pick < 10)
                send_item(make_item(OP_WR_LEAD, 8'($urandom), 16'($urandom),
                                    ($urandom_range(0, 2) == 0) ? 16'h0000
                                                                : rand_code(1'b0),
                                    0, 24'h0));
            else if (pick < 14)
                send_item(make_item(OP_WR_PAIR, 8'($urandom), 16'($urandom),
                                    rand_code(1'b1), 0, 24'h0));
            else
                stream_step();

            if (item_count >= next_drain)
            begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern rotates through four modes with rx_cycle; a long hold-off at set
    // byte counts lets the block fill up and drop in_ready
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        rx_cycle++;
        if (rst_n && out_valid && out_ready)
            rx_taken++;
        if (hold_left == 0 && rx_taken >= next_hold)
        begin
            hold_left = HOLD_CYCLES;
            next_hold += HOLD_EVERY;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 64) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (rx_cycle % 4 != 0);
                default: out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each output byte against the oldest booked one
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (utf8_expected.size() == 0)
            begin
                $error("out_byte: expected nothing, actual %02h", out_byte);
                mismatches++;
            end
            else
            begin
                want = utf8_expected.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
                    mismatches++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // hard stop if the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("testbench: errors");
        $finish;
    end

endmodule
